// ===== rtl/sgirle_pkg.sv =====
// sgirle_pkg: shared types and widths for the sgi rle row decoder
// used by sgi_rle_row_decoder and sgirle_checker; no dependencies
package sgirle_pkg;

    localparam int BYTE_W   = 8;
    localparam int COL_W    = 16;
    localparam int COUNT_W  = 7;
    localparam int ODATA_W  = 32;
    localparam int ROW_WIDTH_RESET = 1;

    typedef enum logic [1:0] {
        PHASE_CTRL = 2'd0,
        PHASE_LIT  = 2'd1,
        PHASE_REP  = 2'd2,
        PHASE_DONE = 2'd3
    } phase_t;

endpackage

// ===== rtl/sgi_rle_row_decoder.sv =====
// sgi_rle_row_decoder: decodes one channel row of sgi rle data into pixel runs
// depends on sgirle_pkg
//
//  channel  direction  handshake              payload
//  s_*      in         s_tvalid / s_tready    tdata row_byte, tlast row_last
//  m_*      out        m_tvalid / m_tready    tdata run fields, tlast row_done,
//                                             tuser row_status
//  cfg_*    in         cfg_valid / cfg_ready  cfg_data row_width
//
// one byte per cycle sustained while m_tready does not stall; a request is held in the input register and
// its result, if any, is registered in the output register
// decode state updates as the byte moves from input register to output register
// reset clears state, column and row_width (to 1); cfg_ready is always high
// a stall on m_tready holds both registers; the input register still takes a
// request while it is empty or the output register is empty or being emptied
module sgi_rle_row_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sgirle_pkg::BYTE_W-1:0] s_tdata,   // [7:0] row_byte
    input  logic                         s_tlast,   // row_last
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sgirle_pkg::ODATA_W-1:0] m_tdata,  // [7:0] run_value, [23:8] run_start,
                                                     // [30:24] run_length, [31] zero
    output logic                         m_tlast,   // row_done
    output logic [0:0]                   m_tuser,   // [0] row_status
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sgirle_pkg::COL_W-1:0] cfg_data   // row_width
);

    logic                            in_valid_reg;
    logic [sgirle_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                            in_last_reg;

    sgirle_pkg::phase_t              phase_reg, phase_next;
    logic [sgirle_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [sgirle_pkg::COL_W-1:0]    column_reg, column_next;
    logic [sgirle_pkg::COL_W-1:0]    row_width_reg;

    logic                            out_valid_reg;
    logic [sgirle_pkg::BYTE_W-1:0]   out_value_reg, out_value_next;
    logic [sgirle_pkg::COL_W-1:0]    out_start_reg, out_start_next;
    logic [sgirle_pkg::COUNT_W-1:0]  out_length_reg, out_length_next;
    logic                            out_done_reg, out_done_next;
    logic                            out_status_reg, out_status_next;

    logic                            advance;
    logic                            fire;
    logic                            produce;
    logic                            have_run;
    sgirle_pkg::phase_t              phase_step;
    logic [sgirle_pkg::COUNT_W-1:0]  count_step;
    logic [sgirle_pkg::COL_W-1:0]    column_step;
    logic [sgirle_pkg::COUNT_W-1:0]  ctrl_count;
    logic [sgirle_pkg::COL_W-1:0]    room;
    logic                            row_full;
    logic                            truncated;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign ctrl_count = in_byte_reg[sgirle_pkg::COUNT_W-1:0];
    assign row_full   = column_reg >= row_width_reg;
    assign room       = row_width_reg - column_reg;

    // next decode state for the byte in the input register
    always_comb
    begin
        phase_step  = phase_reg;
        count_step  = count_reg;
        column_step = column_reg;
        have_run    = 1'b0;
        case (phase_reg)
            sgirle_pkg::PHASE_CTRL:
            begin
                if (row_full || ctrl_count == '0)
                begin
                    phase_step = sgirle_pkg::PHASE_DONE;
                end
                else
                begin
                    if ({{(sgirle_pkg::COL_W-sgirle_pkg::COUNT_W){1'b0}}, ctrl_count} > room)
                        count_step = room[sgirle_pkg::COUNT_W-1:0];
                    else
                        count_step = ctrl_count;
                    phase_step = in_byte_reg[sgirle_pkg::BYTE_W-1] ?
                                 sgirle_pkg::PHASE_LIT : sgirle_pkg::PHASE_REP;
                end
            end
            sgirle_pkg::PHASE_LIT:
            begin
                have_run    = 1'b1;
                column_step = column_reg + 1'b1;
                count_step  = count_reg - 1'b1;
                if (count_step == '0)
                    phase_step = (column_step >= row_width_reg) ?
                                 sgirle_pkg::PHASE_DONE : sgirle_pkg::PHASE_CTRL;
            end
            sgirle_pkg::PHASE_REP:
            begin
                have_run    = 1'b1;
                column_step = column_reg
                            + {{(sgirle_pkg::COL_W-sgirle_pkg::COUNT_W){1'b0}}, count_reg};
                count_step  = '0;
                phase_step  = (column_step >= row_width_reg) ?
                              sgirle_pkg::PHASE_DONE : sgirle_pkg::PHASE_CTRL;
            end
            default:
            begin
                phase_step = phase_reg;
            end
        endcase

        if (in_last_reg)
        begin
            phase_next  = sgirle_pkg::PHASE_CTRL;
            count_next  = '0;
            column_next = '0;
        end
        else
        begin
            phase_next  = phase_step;
            count_next  = count_step;
            column_next = column_step;
        end
    end

    // result fields for the byte in the input register
    always_comb
    begin
        truncated = (phase_step == sgirle_pkg::PHASE_LIT && count_step != '0)
                 || phase_step == sgirle_pkg::PHASE_REP;
        produce         = have_run || in_last_reg;
        out_value_next  = have_run ? in_byte_reg : '0;
        out_start_next  = have_run ? column_reg : '0;
        out_length_next = '0;
        if (have_run)
            out_length_next = (phase_reg == sgirle_pkg::PHASE_LIT) ?
                              sgirle_pkg::COUNT_W'(1) : count_reg;
        out_done_next   = in_last_reg;
        out_status_next = in_last_reg && truncated;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= sgirle_pkg::PHASE_CTRL;
            count_reg     <= '0;
            column_reg    <= '0;
            row_width_reg <= sgirle_pkg::COL_W'(sgirle_pkg::ROW_WIDTH_RESET);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                row_width_reg <= cfg_data;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= fire && produce;
            if (fire)
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                column_reg <= column_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire)
        begin
            out_value_reg  <= out_value_next;
            out_start_reg  <= out_start_next;
            out_length_reg <= out_length_next;
            out_done_reg   <= out_done_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_length_reg, out_start_reg, out_value_reg};
    assign m_tlast  = out_done_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== rtl/sgirle_checker.sv =====
// sgirle_checker: port-level assertions for sgi_rle_row_decoder, with its bind
// depends on sgirle_pkg and sgi_rle_row_decoder
module sgirle_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sgirle_pkg::ODATA_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic [0:0]                    m_tuser
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
    else $error("stalled result changed");

    // truncation only reported when closing a row
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("row_status without row_done");

    // zero-length result is a status-only close with cleared fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[30:24] == '0 |-> m_tlast && m_tdata[23:0] == '0)
    else $error("empty run outside a status-only close");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[31])
    else $error("padding bit set");

endmodule

bind sgi_rle_row_decoder sgirle_checker u_sgirle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
